FILE: rtl/tlpt_pkg.sv
// ----------------------------------------------------------------------------
// tlpt_pkg
// Shared types, codes and field layout of the two-level page table engine.
// ----------------------------------------------------------------------------
package tlpt_pkg;

	// fixed geometry of the directory and of one page table
	localparam int DIR_AW = 10;
	localparam int TBL_AW = 10;

	// entry flag bits
	localparam logic [11:0] FLAG_P     = 12'h001;
	localparam logic [11:0] FLAG_U     = 12'h004;
	localparam logic [11:0] FLAG_AD    = 12'h060;
	localparam int          BIT_P      = 0;
	localparam int          BIT_PS     = 7;
	localparam int          FLAG_LIM_W = 5;

	// request modes
	localparam logic [1:0] MODE_MAP       = 2'd0;
	localparam logic [1:0] MODE_RESOLVE   = 2'd1;
	localparam logic [1:0] MODE_DIR_WRITE = 2'd2;

	// result status codes
	localparam logic [2:0] ST_OK          = 3'd0;
	localparam logic [2:0] ST_NULL_PAGE   = 3'd1;
	localparam logic [2:0] ST_BAD_FLAGS   = 3'd2;
	localparam logic [2:0] ST_MISALIGNED  = 3'd3;
	localparam logic [2:0] ST_CONFLICT_4M = 3'd4;
	localparam logic [2:0] ST_CONFLICT    = 3'd5;
	localparam logic [2:0] ST_POOL_FULL   = 3'd6;

	// input stream layout
	localparam int IN_TDATA_W = 112;
	localparam int IN_TUSER_W = 2;
	localparam int IN_VA_LO   = 0;
	localparam int IN_PA_LO   = 32;
	localparam int IN_FL_LO   = 64;
	localparam int IN_DW_LO   = 76;

	// output stream layout
	localparam int OUT_TDATA_W = 72;
	localparam int CFG_W       = 20;

	// one result item, status in the lowest bits
	typedef struct packed {
		logic [31:0] raw_entry;
		logic [31:0] phys_addr_out;
		logic        present;
		logic [2:0]  status;
	} rsp_t;

	localparam int RSP_W = $bits(rsp_t);

endpackage

FILE: rtl/two_level_page_table_engine_top.sv
// ----------------------------------------------------------------------------
// two_level_page_table_engine_top
// One 32-bit page directory and a pool of page tables: map, resolve, write.
// ----------------------------------------------------------------------------
// Requests are handled one at a time. A request is taken in S_IDLE, the
// directory entry is read in S_DIR, and a walk into a page table adds a
// read in S_PTE, after which the result waits in S_RESP for the output
// register. The directory and pool RAMs have a registered read. A map that
// allocates a new page table clears it first in S_CLR_TBL. After reset the
// directory is swept to zero, during which s_tready stays low;
// configuration writes are taken at any time. A finished result waits in
// the output register while the next request is already being worked on.
module two_level_page_table_engine_top #(
	parameter int NUM_TABLES = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// configuration: pool_base_page
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [tlpt_pkg::CFG_W-1:0]       cfg_data,
	// request stream
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// virt_addr, phys_addr_in, entry_flags, dir_word, zero pad
	input  logic [tlpt_pkg::IN_TDATA_W-1:0]  s_tdata,
	// mode
	input  logic [tlpt_pkg::IN_TUSER_W-1:0]  s_tuser,
	// result stream
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// status, present, phys_addr_out, raw_entry, zero pad
	output logic [tlpt_pkg::OUT_TDATA_W-1:0] m_tdata
);

	import tlpt_pkg::*;

	localparam int SLOT_W  = (NUM_TABLES > 1) ? $clog2(NUM_TABLES) : 1;
	localparam int POOL_D  = NUM_TABLES * (2 ** TBL_AW);
	localparam int POOL_AW = $clog2(POOL_D);
	localparam int USED_W  = $clog2(NUM_TABLES + 1);

	typedef enum logic [2:0] {
		S_CLR_DIR,
		S_IDLE,
		S_DIR,
		S_PTE,
		S_CLR_TBL,
		S_RESP
	} state_t;

	state_t                   state_q;
	logic [TBL_AW-1:0]        cnt_q;
	logic [USED_W-1:0]        used_q;
	logic [CFG_W-1:0]         base_q;
	logic                     m_tvalid_q;
	logic [OUT_TDATA_W-1:0]   m_tdata_q;

	// latched request
	logic [1:0]               mode_q;
	logic [31:0]              va_q;
	logic [31:0]              pa_q;
	logic [11:0]              fl_q;
	logic [31:0]              dw_q;
	logic [SLOT_W-1:0]        slot_q;
	rsp_t                     res_q;

	// memory ports
	logic                     dir_we;
	logic [DIR_AW-1:0]        dir_waddr;
	logic [31:0]              dir_wdata;
	logic                     dir_re;
	logic [DIR_AW-1:0]        dir_raddr;
	logic [31:0]              dir_rdata;
	logic                     pool_we;
	logic [POOL_AW-1:0]       pool_waddr;
	logic [31:0]              pool_wdata;
	logic                     pool_re;
	logic [POOL_AW-1:0]       pool_raddr;
	logic [31:0]              pool_rdata;

	// decisions
	logic                     s_xfer;
	logic                     res_load;
	logic [CFG_W-1:0]         pool_off;
	logic                     in_pool;
	logic [31:0]              want;
	logic [TBL_AW-1:0]        ti;
	rsp_t                     dir_res;
	state_t                   dir_next;
	logic [SLOT_W-1:0]        dir_slot;
	logic                     dir_alloc;
	rsp_t                     pte_res;

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == S_IDLE);
	assign s_xfer    = s_tvalid & s_tready;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;
	assign res_load  = (state_q == S_RESP) && (!m_tvalid_q || m_tready);

	assign ti        = va_q[21:12];
	assign want      = pa_q | {20'd0, fl_q};
	assign pool_off  = dir_rdata[31:12] - base_q;
	assign in_pool   = (pool_off < CFG_W'(NUM_TABLES));
	assign dir_raddr = s_tdata[IN_VA_LO+31 -: DIR_AW];

	// directory and pool storage
	tlpt_ram #(
		.WIDTH(32),
		.DEPTH(2 ** DIR_AW)
	) u_dir_ram (
		.clk  (clk),
		.we   (dir_we),
		.waddr(dir_waddr),
		.wdata(dir_wdata),
		.re   (dir_re),
		.raddr(dir_raddr),
		.rdata(dir_rdata)
	);

	tlpt_ram #(
		.WIDTH(32),
		.DEPTH(POOL_D)
	) u_pool_ram (
		.clk  (clk),
		.we   (pool_we),
		.waddr(pool_waddr),
		.wdata(pool_wdata),
		.re   (pool_re),
		.raddr(pool_raddr),
		.rdata(pool_rdata)
	);

	// memory control and per-state decisions
	always_comb begin
		dir_we     = 1'b0;
		dir_waddr  = va_q[31:22];
		dir_wdata  = dw_q;
		dir_re     = s_xfer;
		pool_we    = 1'b0;
		pool_waddr = POOL_AW'({slot_q, ti});
		pool_wdata = want;
		pool_re    = 1'b0;
		dir_res    = '0;
		dir_next   = S_RESP;
		dir_slot   = SLOT_W'(pool_off);
		dir_alloc  = 1'b0;
		pte_res    = '0;
		case (state_q)
			S_CLR_DIR: begin
				dir_we    = 1'b1;
				dir_waddr = cnt_q;
				dir_wdata = '0;
			end
			S_DIR: begin
				case (mode_q)
					MODE_MAP: begin
						if (va_q == '0) begin
							dir_res.status = ST_NULL_PAGE;
						end else if (fl_q[11:FLAG_LIM_W] != '0) begin
							dir_res.status = ST_BAD_FLAGS;
						end else if ((va_q[11:0] | pa_q[11:0]) != '0) begin
							dir_res.status = ST_MISALIGNED;
						end else if (!dir_rdata[BIT_P]) begin
							if (used_q >= USED_W'(NUM_TABLES)) begin
								dir_res.status = ST_POOL_FULL;
							end else begin
								// allocate the next pool table and hook it in
								dir_alloc = 1'b1;
								dir_slot  = SLOT_W'(used_q);
								dir_next  = S_CLR_TBL;
								dir_we    = 1'b1;
								dir_wdata = {base_q + CFG_W'(used_q), fl_q | FLAG_U};
							end
						end else if (dir_rdata[BIT_PS]) begin
							dir_res.status = ST_CONFLICT_4M;
						end else if (!in_pool) begin
							dir_res.status = ST_POOL_FULL;
						end else begin
							pool_re  = 1'b1;
							dir_next = S_PTE;
						end
					end
					MODE_RESOLVE: begin
						if (dir_rdata[BIT_P]) begin
							if (dir_rdata[BIT_PS]) begin
								dir_res.present       = 1'b1;
								dir_res.phys_addr_out = {dir_rdata[31:22], va_q[21:0]};
								dir_res.raw_entry     = dir_rdata;
							end else if (in_pool) begin
								pool_re  = 1'b1;
								dir_next = S_PTE;
							end
						end
					end
					MODE_DIR_WRITE: begin
						dir_we = 1'b1;
					end
					default: begin
					end
				endcase
			end
			S_CLR_TBL: begin
				// sweep the new table, placing the mapped entry on the way
				pool_we    = 1'b1;
				pool_waddr = POOL_AW'({slot_q, cnt_q});
				pool_wdata = (cnt_q == ti) ? want : '0;
			end
			S_PTE: begin
				if (mode_q == MODE_MAP) begin
					if (pool_rdata[BIT_P] && fl_q[BIT_P] &&
					    ((pool_rdata & ~{20'd0, FLAG_AD}) != want)) begin
						pte_res.status = ST_CONFLICT;
					end else begin
						pool_we = 1'b1;
					end
				end else if (pool_rdata[BIT_P]) begin
					pte_res.present       = 1'b1;
					pte_res.phys_addr_out = {pool_rdata[31:12], va_q[11:0]};
					pte_res.raw_entry     = pool_rdata;
				end
			end
			default: begin
			end
		endcase
	end

	always_comb pool_raddr = POOL_AW'({dir_slot, ti});

	// sequencer, pool counter, configuration and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLR_DIR;
			cnt_q      <= '0;
			used_q     <= '0;
			base_q     <= '0;
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
		end else begin
			if (cfg_valid) begin
				base_q <= cfg_data;
			end
			// output register: load a new result or drop after its transfer
			if (res_load) begin
				m_tvalid_q <= 1'b1;
				m_tdata_q  <= {(OUT_TDATA_W - RSP_W)'(0), res_q};
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				S_CLR_DIR: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == '1) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (s_xfer) begin
						state_q <= S_DIR;
					end
				end
				S_DIR: begin
					state_q <= dir_next;
					cnt_q   <= '0;
					if (dir_alloc) begin
						used_q <= used_q + 1'b1;
					end
				end
				S_CLR_TBL: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == '1) begin
						state_q <= S_RESP;
					end
				end
				S_PTE: begin
					state_q <= S_RESP;
				end
				S_RESP: begin
					if (res_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// request and result payload
	always_ff @(posedge clk) begin
		if (s_xfer) begin
			mode_q <= s_tuser;
			va_q   <= s_tdata[IN_VA_LO +: 32];
			pa_q   <= s_tdata[IN_PA_LO +: 32];
			fl_q   <= s_tdata[IN_FL_LO +: 12];
			dw_q   <= s_tdata[IN_DW_LO +: 32];
		end
		if (state_q == S_DIR) begin
			res_q  <= dir_res;
			slot_q <= dir_slot;
		end
		if (state_q == S_PTE) begin
			res_q <= pte_res;
		end
	end

endmodule

FILE: rtl/tlpt_ram.sv
// ----------------------------------------------------------------------------
// tlpt_ram
// Generic simple dual-port RAM, one write and one read port, registered read.
// ----------------------------------------------------------------------------
module tlpt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port, registered
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: rtl/tlpt_checker.sv
// ----------------------------------------------------------------------------
// tlpt_checker
// Port-level checks of the page table engine, bound to the top level.
// ----------------------------------------------------------------------------
module tlpt_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             s_tvalid,
	input logic                             s_tready,
	input logic                             m_tvalid,
	input logic                             m_tready,
	input logic [tlpt_pkg::OUT_TDATA_W-1:0] m_tdata
);

	import tlpt_pkg::*;

	// one request in flight at a time
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request taken while another is in flight");

	// a present result always carries ok status and a present raw entry
	a_present_ok: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[3] |-> m_tdata[2:0] == ST_OK && m_tdata[36 + BIT_P])
		else $error("present result with bad status or entry");

	// nothing found means zero address and entry
	a_absent_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[3] |-> m_tdata[67:4] == '0)
		else $error("absent result with non-zero payload");

	// status stays within the defined codes
	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[2:0] != 3'd7)
		else $error("undefined status code");

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result changed");

endmodule

bind two_level_page_table_engine_top tlpt_checker u_tlpt_checker (.*);

FILE: dv/two_level_page_table_engine_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// two_level_page_table_engine_checker
// Watches the configuration, request and result channels of the page table
// engine. It keeps its own directory, table pool and allocation count, works
// out the result of every accepted request and compares each result transfer
// field by field with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module two_level_page_table_engine_checker
	import tlpt_pkg::*;
#(
	parameter int NUM_TABLES = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_valid,
	input  logic                   cfg_ready,
	input  logic [CFG_W-1:0]       cfg_data,
	input  logic                   s_tvalid,
	input  logic                   s_tready,
	// virt_addr, phys_addr_in, entry_flags, dir_word, zero pad
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	// mode
	input  logic [IN_TUSER_W-1:0]  s_tuser,
	input  logic                   m_tvalid,
	input  logic                   m_tready,
	// status, present, phys_addr_out, raw_entry, zero pad
	input  logic [OUT_TDATA_W-1:0] m_tdata,
	output int                     fail_count,
	output int                     pending
);

	localparam int DIR_N = 1 << DIR_AW;
	localparam int TBL_N = 1 << TBL_AW;

	// predicted engine state
	logic [31:0]      dir_mem  [DIR_N];
	logic [31:0]      pool_mem [NUM_TABLES*TBL_N];
	int               tables_used;
	logic [CFG_W-1:0] pool_base;

	// results owed by the engine, oldest first
	rsp_t due_rsp [$];

	rsp_t got_rsp;
	rsp_t exp_rsp;
	int   d;

	// apply one request to the predicted state and return its result
	function automatic rsp_t serve_request(input logic [1:0] mode, input logic [31:0] va,
			input logic [31:0] pa, input logic [11:0] fl, input logic [31:0] dw);
		rsp_t        r;
		logic [31:0] de;
		logic [31:0] pte;
		logic [31:0] want;
		logic [19:0] off;
		int          slot;
		int          ti;
		int          k;
		r = '0;
		de = dir_mem[va[31:22]];
		ti = int'(va[21:12]);
		slot = -1;
		case (mode)
			MODE_MAP: begin
				// checks in priority order, first failure wins
				if (va == 32'd0) begin
					r.status = ST_NULL_PAGE;
				end else if (fl[11:FLAG_LIM_W] != '0) begin
					r.status = ST_BAD_FLAGS;
				end else if ((va[11:0] | pa[11:0]) != 12'd0) begin
					r.status = ST_MISALIGNED;
				end else if (!de[BIT_P]) begin
					// absent directory entry: take and clear the next pool table
					if (tables_used >= NUM_TABLES) begin
						r.status = ST_POOL_FULL;
					end else begin
						slot = tables_used;
						tables_used++;
						for (k = 0; k < TBL_N; k++)
							pool_mem[slot*TBL_N + k] = '0;
						off = pool_base + 20'(slot);
						dir_mem[va[31:22]] = {off, fl | FLAG_U};
					end
				end else if (de[BIT_PS]) begin
					r.status = ST_CONFLICT_4M;
				end else begin
					off = de[31:12] - pool_base;
					if (off < NUM_TABLES)
						slot = int'(off);
					else
						r.status = ST_POOL_FULL;
				end
				// table entry write, refused if a differing present entry is there and the new entry is present
				if (slot >= 0) begin
					want = {pa[31:12], fl};
					pte = pool_mem[slot*TBL_N + ti];
					if (pte[BIT_P] && ((pte & ~{20'd0, FLAG_AD}) != want) && fl[BIT_P])
						r.status = ST_CONFLICT;
					else
						pool_mem[slot*TBL_N + ti] = want;
				end
			end
			MODE_RESOLVE: begin
				if (de[BIT_P]) begin
					if (de[BIT_PS]) begin
						// 4M page straight from the directory
						r.present = 1'b1;
						r.phys_addr_out = {de[31:22], va[21:0]};
						r.raw_entry = de;
					end else begin
						off = de[31:12] - pool_base;
						if (off < NUM_TABLES) begin
							pte = pool_mem[int'(off)*TBL_N + ti];
							if (pte[BIT_P]) begin
								r.present = 1'b1;
								r.phys_addr_out = {pte[31:12], va[11:0]};
								r.raw_entry = pte;
							end
						end
					end
				end
			end
			MODE_DIR_WRITE: begin
				dir_mem[va[31:22]] = dw;
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	// follow the channels, predict on request transfers, compare on result transfers
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (d = 0; d < DIR_N; d++)
				dir_mem[d] = '0;
			tables_used = 0;
			pool_base = '0;
			due_rsp.delete();
			fail_count = 0;
			pending <= 0;
		end else begin
			if (cfg_valid && cfg_ready)
				pool_base = cfg_data;
			if (s_tvalid && s_tready)
				due_rsp.push_back(serve_request(s_tuser, s_tdata[IN_VA_LO +: 32],
					s_tdata[IN_PA_LO +: 32], s_tdata[IN_FL_LO +: 12],
					s_tdata[IN_DW_LO +: 32]));
			if (m_tvalid && m_tready) begin
				got_rsp = m_tdata[RSP_W-1:0];
				if (due_rsp.size() == 0) begin
					fail_count++;
					$error("result transfer with no request outstanding: %h", got_rsp);
				end else begin
					exp_rsp = due_rsp.pop_front();
					if (got_rsp.status !== exp_rsp.status) begin
						fail_count++;
						$error("status: expected %0d, got %0d", exp_rsp.status, got_rsp.status);
					end
					if (got_rsp.present !== exp_rsp.present) begin
						fail_count++;
						$error("present: expected %0d, got %0d", exp_rsp.present,
							got_rsp.present);
					end
					if (got_rsp.phys_addr_out !== exp_rsp.phys_addr_out) begin
						fail_count++;
						$error("phys_addr_out: expected %h, got %h", exp_rsp.phys_addr_out,
							got_rsp.phys_addr_out);
					end
					if (got_rsp.raw_entry !== exp_rsp.raw_entry) begin
						fail_count++;
						$error("raw_entry: expected %h, got %h", exp_rsp.raw_entry,
							got_rsp.raw_entry);
					end
				end
			end
			pending <= due_rsp.size();
		end
	end

endmodule

FILE: dv/tb_two_level_page_table_engine_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_two_level_page_table_engine_top
// Stimulus and verdict for the page table engine. A directed list covers each
// status code, 4M and 4K walks, unmap and directory writes; then random
// requests concentrated on a few directory slots run over several pool base
// settings, with random gaps on the request side and stalls on the result
// side. Prediction and comparison live in the checker beside the engine.
// ----------------------------------------------------------------------------
module tb_two_level_page_table_engine_top;
	import tlpt_pkg::*;

	localparam int         NUM_TABLES  = 16;
	localparam int         DIR_N       = 1 << DIR_AW;
	localparam int         RUN_ITEMS   = 1000;
	localparam int         PHASES      = 4;
	localparam int         HOT_N       = 12;
	localparam logic [1:0] MODE_UNUSED = 2'd3;

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [CFG_W-1:0]       cfg_data;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata;
	logic [IN_TUSER_W-1:0]  s_tuser;
	logic                   m_tvalid;
	logic                   m_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;
	int                     fail_count;
	int                     pending;

	// view of the directory kept only to steer stimulus away from uncleared tables
	logic [31:0]      dir_view [DIR_N];
	int               tables_given;
	logic [CFG_W-1:0] base_view;
	logic [9:0]       hot_dir [HOT_N];
	bit               quiet_tx;
	bit               quiet_rx;
	int               rx_n;
	int               rx_stall;
	int               ph;
	int               n;

	two_level_page_table_engine_top #(
		.NUM_TABLES(NUM_TABLES)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	two_level_page_table_engine_checker #(
		.NUM_TABLES(NUM_TABLES)
	) checker_i (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.fail_count(fail_count),
		.pending   (pending)
	);

	// clock and a single reset pulse
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
	end

	// watchdog
	initial begin
		#2ms;
		$display("simulation failed");
		$finish;
	end

	// result side: random stall before each transfer, with quiet stretches
	initial begin
		m_tready = 1'b0;
		rx_n = 0;
		quiet_rx = 1'b0;
		@(posedge arst_n);
		forever begin
			if (rx_n % 50 == 0)
				quiet_rx = ($urandom_range(0, 3) == 0);
			rx_stall = quiet_rx ? 0 : $urandom_range(0, 12);
			@(negedge clk);
			if (rx_stall != 0) begin
				m_tready <= 1'b0;
				repeat (rx_stall) @(negedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!(m_tvalid && m_tready));
			rx_n++;
		end
	end

	// one request transfer after a random gap
	task automatic send_req(input logic [1:0] md, input logic [31:0] va, input logic [31:0] pa,
			input logic [11:0] fl, input logic [31:0] dw);
		logic [IN_TDATA_W-1:0] word;
		int                    gap;
		word = '0;
		word[IN_VA_LO +: 32] = va;
		word[IN_PA_LO +: 32] = pa;
		word[IN_FL_LO +: 12] = fl;
		word[IN_DW_LO +: 32] = dw;
		gap = quiet_tx ? 0 : $urandom_range(0, 12);
		@(negedge clk);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= word;
		s_tuser <= md;
		do @(posedge clk); while (!s_tready);
	endtask

	// drop valid and hold off until every result has come back
	task automatic wait_drained();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending != 0) @(posedge clk);
	endtask

	task automatic write_pool_base(input logic [CFG_W-1:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		base_view = value;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// keep requests off uncleared tables, follow allocation, then send
	task automatic issue(input logic [1:0] md_in, input logic [31:0] va, input logic [31:0] pa,
			input logic [11:0] fl, input logic [31:0] dw_in);
		logic [1:0]  md;
		logic [31:0] dw;
		logic [31:0] de;
		logic [19:0] off;
		md = md_in;
		dw = dw_in;
		de = dir_view[va[31:22]];
		off = de[31:12] - base_view;
		// entry names a pool table that was never handed out: rewrite it instead
		if ((md == MODE_MAP || md == MODE_RESOLVE) && de[BIT_P] && !de[BIT_PS] &&
				off < NUM_TABLES && off >= tables_given) begin
			md = MODE_DIR_WRITE;
			dw = '0;
		end
		if (md == MODE_DIR_WRITE) begin
			dir_view[va[31:22]] = dw;
		end else if (md == MODE_MAP && va != 32'd0 && fl[11:FLAG_LIM_W] == '0 &&
				(va[11:0] | pa[11:0]) == 12'd0 && !de[BIT_P] && tables_given < NUM_TABLES) begin
			dir_view[va[31:22]] = {base_view + 20'(tables_given), fl | FLAG_U};
			tables_given++;
		end
		send_req(md, va, pa, fl, dw);
	endtask

	// random request, mostly on a few hot directory slots and table indexes
	task automatic random_req();
		logic [1:0]  md;
		logic [31:0] va;
		logic [31:0] pa;
		logic [31:0] dw;
		logic [11:0] fl;
		logic [9:0]  di;
		logic [9:0]  ti;
		int          pick;
		di = ($urandom_range(0, 99) < 85) ? hot_dir[$urandom_range(0, HOT_N-1)] : 10'($urandom);
		ti = ($urandom_range(0, 3) != 0) ? 10'($urandom_range(0, 7)) : 10'($urandom);
		pa = {($urandom_range(0, 1) != 0) ? 20'($urandom_range(1, 3)) : 20'($urandom), 12'd0};
		dw = '0;
		pick = $urandom_range(0, 99);
		if (pick < 8) begin
			pa = '0;
			fl = '0;
		end else if (pick < 15) begin
			fl = 12'($urandom);
		end else if (pick < 55) begin
			fl = ($urandom_range(0, 1) != 0) ? 12'h003 : 12'h001;
		end else begin
			fl = 12'($urandom_range(0, 31));
		end
		pick = $urandom_range(0, 99);
		if (pick < 50) begin
			md = MODE_MAP;
			va = {di, ti, 12'd0};
			pick = $urandom_range(0, 99);
			if (pick < 5)
				va = '0;
			else if (pick < 11)
				va[11:0] = 12'($urandom);
			else if (pick < 15)
				pa[11:0] = 12'($urandom);
			else if (pick < 21)
				va = $urandom;
		end else if (pick < 82) begin
			md = MODE_RESOLVE;
			va = ($urandom_range(0, 99) < 8) ? $urandom : {di, ti, 12'($urandom)};
		end else if (pick < 96) begin
			md = MODE_DIR_WRITE;
			va = {di, 22'($urandom)};
			pick = $urandom_range(0, 3);
			if (pick == 0)
				dw = {24'($urandom), 1'b1, 6'($urandom), 1'b1};
			else if (pick == 1 && tables_given > 0)
				dw = {base_view + 20'($urandom_range(0, tables_given-1)), 4'($urandom), 1'b0,
					6'($urandom), 1'b1};
			else if (pick == 2)
				dw = '0;
			else
				dw = $urandom;
		end else begin
			md = MODE_UNUSED;
			va = $urandom;
			pa = $urandom;
			fl = 12'($urandom);
			dw = $urandom;
		end
		issue(md, va, pa, fl, dw);
	endtask

	// stimulus
	initial begin
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		quiet_tx = 1'b0;
		tables_given = 0;
		base_view = '0;
		for (n = 0; n < DIR_N; n++)
			dir_view[n] = '0;
		hot_dir[0] = 10'h000;
		hot_dir[1] = 10'h3FF;
		for (n = 2; n < HOT_N; n++)
			hot_dir[n] = 10'($urandom);
		@(posedge arst_n);

		// pool base near the top so that table pages wrap around
		write_pool_base(20'hFFFF9);

		// directed: empty walk, each map check, 4K and 4M walks, unmap, shared table
		issue(MODE_RESOLVE, 32'h0040_0000, '0, '0, '0);
		issue(MODE_MAP, 32'h0000_0000, 32'h0000_1000, 12'h001, '0);
		issue(MODE_MAP, 32'h0040_0000, 32'h0000_1000, 12'h020, '0);
		issue(MODE_MAP, 32'h0040_0000, 32'h0000_1000, 12'hFFF, '0);
		issue(MODE_MAP, 32'h0040_0800, 32'h0000_1000, 12'h001, '0);
		issue(MODE_MAP, 32'h0040_0000, 32'h0000_1001, 12'h001, '0);
		issue(MODE_MAP, 32'h0040_0000, 32'hFFFF_F000, 12'h01F, '0);
		issue(MODE_RESOLVE, 32'h0040_0ABC, '0, '0, '0);
		issue(MODE_MAP, 32'h0040_0000, 32'h0000_2000, 12'h003, '0);
		issue(MODE_MAP, 32'h0040_0000, 32'hFFFF_F000, 12'h01F, '0);
		issue(MODE_MAP, 32'h0040_0000, '0, '0, '0);
		issue(MODE_RESOLVE, 32'h0040_0FFF, '0, '0, '0);
		issue(MODE_MAP, 32'h0080_0000, '0, '0, '0);
		issue(MODE_DIR_WRITE, 32'hFFC0_0000, '0, '0, 32'hFFC0_0083);
		issue(MODE_RESOLVE, 32'hFFFF_FFFF, '0, '0, '0);
		issue(MODE_MAP, 32'hFFC0_1000, 32'h0000_3000, 12'h001, '0);
		issue(MODE_DIR_WRITE, 32'h8000_0000, '0, '0, {base_view + 20'h00800, 12'h001});
		issue(MODE_RESOLVE, 32'h8000_0000, '0, '0, '0);
		issue(MODE_MAP, 32'h8000_0000, 32'h0000_5000, 12'h001, '0);
		issue(MODE_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 12'hFFF, 32'hFFFF_FFFF);
		issue(MODE_DIR_WRITE, 32'h00C0_0000, '0, '0, {base_view, 12'h007});
		issue(MODE_RESOLVE, 32'h00C0_0000, '0, '0, '0);
		issue(MODE_MAP, 32'h00C0_1000, 32'hFFFF_F000, 12'h003, '0);
		issue(MODE_RESOLVE, 32'h0040_1234, '0, '0, '0);
		issue(MODE_MAP, 32'hFFFF_F000, 32'hFFFF_F000, 12'h01F, '0);

		// random phases, each with its own pool base
		for (ph = 0; ph < PHASES; ph++) begin
			if (ph != 0) begin
				wait_drained();
				case (ph)
					1: write_pool_base(20'h00000);
					2: write_pool_base(20'hFFFFF);
					default: write_pool_base(20'($urandom));
				endcase
			end
			for (n = 0; n < RUN_ITEMS / PHASES; n++) begin
				if (n % 50 == 0)
					quiet_tx = ($urandom_range(0, 3) == 0);
				if ($urandom_range(0, 79) == 0)
					wait_drained();
				random_req();
			end
		end

		wait_drained();
		repeat (16) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
